/* hw/rtl/glos_pkg.sv */
// Shared constants and control types for the grid line-of-sight walker.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package glos_pkg;

   localparam int MAP_WIDTH  = 16;
   localparam int MAP_HEIGHT = 16;
   localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W     = $clog2(MAP_DEPTH);
   localparam int COORD_W    = 4;
   localparam int DIFF_W     = COORD_W;
   localparam int ERR_W      = COORD_W + 3;
   localparam int TWICE_W    = ERR_W + 1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic write;
      logic load;
      logic step;
   } glos_cmd_type;

   typedef struct packed {
      logic hit;
      logic at_end;
   } glos_status_type;

endpackage

/* hw/rtl/grid_line_of_sight_walker_core.sv */
// Top level of the grid line-of-sight walker.
// Depends on glos_pkg, glos_ctrl and glos_datapath.
//
// Usage:
//   Input channel: raise start with req_command and its fields; the item is
//   taken at a rising edge where start is high and busy is low.
//   A write item (req_command = 0) stores req_blocks for cell
//   (req_cell_x, req_cell_y) and gives no result.
//   A query item (req_command = 1) walks the Bresenham line from
//   (req_from_x, req_from_y) to (req_to_x, req_to_y), one cell per cycle,
//   checking each intermediate cell against the map memory.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_clear.
//   The receiver cannot stall; it must take the result in that cycle.
//   A query that runs to its end cell gives its result once the walk reaches
//   it; a blocked query ends early. The walk does one map read per step.
//   busy is high from acceptance of a query until the result cycle, in which
//   a new item may already be taken. Writes keep busy low.
//   Reset: synchronous, active high; clears the controller. The map is not
//   cleared and must be written before cells are queried.
`timescale 1ns / 1ps

module grid_line_of_sight_walker_core
   import glos_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   input  logic               req_blocks,
   input  logic [COORD_W-1:0] req_from_x,
   input  logic [COORD_W-1:0] req_from_y,
   input  logic [COORD_W-1:0] req_to_x,
   input  logic [COORD_W-1:0] req_to_y,
   output logic               rsp_valid,
   output logic               rsp_clear
);

   glos_cmd_type    cmd;
   glos_status_type status;

   glos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_command),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_clear (rsp_clear)
   );

   glos_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .cell_x (req_cell_x),
      .cell_y (req_cell_y),
      .blocks (req_blocks),
      .from_x (req_from_x),
      .from_y (req_from_y),
      .to_x   (req_to_x),
      .to_y   (req_to_y),
      .status (status)
   );

endmodule

/* hw/rtl/glos_datapath.sv */
// Datapath: blocking map memory, Bresenham position and error registers.
// Depends on glos_pkg; driven by glos_ctrl through glos_cmd_type.
`timescale 1ns / 1ps

module glos_datapath
   import glos_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  glos_cmd_type         cmd,
   input  logic [COORD_W-1:0]   cell_x,
   input  logic [COORD_W-1:0]   cell_y,
   input  logic                 blocks,
   input  logic [COORD_W-1:0]   from_x,
   input  logic [COORD_W-1:0]   from_y,
   input  logic [COORD_W-1:0]   to_x,
   input  logic [COORD_W-1:0]   to_y,
   output glos_status_type      status
);

   logic                      map_mem [MAP_DEPTH];

   logic [COORD_W-1:0]        cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]        cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]        end_x_ff;
   logic [COORD_W-1:0]        end_y_ff;
   logic [DIFF_W-1:0]         adx_ff, adx_in;
   logic [DIFF_W-1:0]         ady_ff, ady_in;
   logic                      pos_x_ff, pos_y_ff;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      rd_data_ff;
   logic                      rd_outside_ff;

   logic signed [TWICE_W-1:0] twice;
   logic signed [TWICE_W-1:0] adx_s;
   logic signed [TWICE_W-1:0] ady_s;
   logic                      move_x, move_y;
   logic                      next_is_end;
   logic                      next_inside;
   logic                      wr_inside;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         rd_addr;

   always_comb begin
      adx_in = (to_x > from_x) ? (to_x - from_x) : (from_x - to_x);
      ady_in = (to_y > from_y) ? (to_y - from_y) : (from_y - to_y);
   end

   assign adx_s  = $signed(TWICE_W'(adx_ff));
   assign ady_s  = $signed(TWICE_W'(ady_ff));
   assign twice  = $signed(TWICE_W'(err_ff)) <<< 1;
   assign move_x = twice > -ady_s;
   assign move_y = twice < adx_s;

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in   = err_ff;
      if (move_x) begin
         cur_x_in = pos_x_ff ? cur_x_ff + COORD_W'(1) : cur_x_ff - COORD_W'(1);
         err_in   = err_in - $signed(ERR_W'(ady_ff));
      end
      if (move_y) begin
         cur_y_in = pos_y_ff ? cur_y_ff + COORD_W'(1) : cur_y_ff - COORD_W'(1);
         err_in   = err_in + $signed(ERR_W'(adx_ff));
      end
   end

   assign next_is_end = (cur_x_in == end_x_ff) && (cur_y_in == end_y_ff);
   assign next_inside = (int'(cur_x_in) < MAP_WIDTH) && (int'(cur_y_in) < MAP_HEIGHT);
   assign wr_inside   = (int'(cell_x) < MAP_WIDTH) && (int'(cell_y) < MAP_HEIGHT);
   assign wr_addr     = ADDR_W'(cell_y) * ADDR_W'(MAP_WIDTH) + ADDR_W'(cell_x);
   assign rd_addr     = ADDR_W'(cur_y_in) * ADDR_W'(MAP_WIDTH) + ADDR_W'(cur_x_in);
   assign rd_valid_in = cmd.step && !next_is_end;

   always_ff @(posedge clock) begin
      if (cmd.write && wr_inside) begin
         map_mem[wr_addr] <= blocks;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && !next_is_end && next_inside) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= from_x;
         cur_y_ff <= from_y;
         end_x_ff <= to_x;
         end_y_ff <= to_y;
         adx_ff   <= adx_in;
         ady_ff   <= ady_in;
         pos_x_ff <= to_x > from_x;
         pos_y_ff <= to_y > from_y;
         err_ff   <= $signed(ERR_W'(adx_in)) - $signed(ERR_W'(ady_in));
      end else if (cmd.step) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         err_ff        <= err_in;
         rd_outside_ff <= !next_inside;
      end
   end

   assign status.hit    = rd_valid_ff && (rd_outside_ff || rd_data_ff);
   assign status.at_end = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);

endmodule

/* hw/rtl/glos_ctrl.sv */
// Controller: accepts items, sequences the walk and drives the result strobe.
// Depends on glos_pkg; commands glos_datapath and reads its status.
`timescale 1ns / 1ps

module glos_ctrl
   import glos_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             command,
   input  glos_status_type  status,
   output glos_cmd_type     cmd,
   output logic             busy,
   output logic             rsp_valid,
   output logic             rsp_clear
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_clear_ff, rsp_clear_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_clear_in = rsp_clear_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (command == CMD_QUERY) begin
                  cmd.load = 1'b1;
                  state_in = ST_WALK;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (status.hit) begin
               rsp_valid_in = 1'b1;
               rsp_clear_in = 1'b0;
               state_in     = ST_IDLE;
            end else if (status.at_end) begin
               rsp_valid_in = 1'b1;
               rsp_clear_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_clear_ff <= rsp_clear_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_clear = rsp_clear_ff;

   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_WALK))
      else $error("result strobe without a walk in progress");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && command == CMD_QUERY) |=> busy)
      else $error("query accepted but walk not started");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && command == CMD_WRITE) |=> (!rsp_valid && !busy))
      else $error("write caused a result or a walk");

   a_walk_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!status.at_end && !status.hit))
      else $error("step issued after the walk finished");

endmodule
